FILE: rtl/nsc_pkg.sv
// Shared types, constants and helpers for the NMEA sentence checker.
package nsc_pkg;

    // Longest sentence accepted as valid, in bytes
    localparam logic [7:0] MAX_LEN = 8'd82;
    // Shortest sentence that can hold a start byte, '*', two hex digits, CR and LF
    localparam logic [7:0] MIN_LEN = 8'd6;
    // Position counter saturates here
    localparam logic [7:0] POS_MAX = 8'hFF;
    // First byte position at which the byte leaving the tail window joins the checksum
    localparam logic [7:0] XOR_START_POS = 8'd6;

    // Positions of the three sentence type bytes
    localparam logic [7:0] TYPE_POS0 = 8'd3;
    localparam logic [7:0] TYPE_POS1 = 8'd4;
    localparam logic [7:0] TYPE_POS2 = 8'd5;

    // Tail window depth
    localparam int TAIL_DEPTH = 5;

    // Framing characters
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // ASCII bases for upper-case hex digits
    localparam logic [7:0] HEX_NUM_BASE   = 8'd48;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd55;

    typedef enum logic [2:0] {
        ST_GOOD      = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BAD_TERM  = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    // One registered byte handed to the checker core
    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] data;
    } nsc_byte_t;

    // One verdict for a finished sentence
    typedef struct packed {
        status_t     status;
        logic [7:0]  checksum;
        logic [7:0]  length;
        logic [23:0] stype;
    } nsc_verdict_t;

    // Upper-case ASCII hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] wide;
        wide = {4'b0000, nibble};
        if (nibble < 4'd10)
            return HEX_NUM_BASE + wide;
        else
            return HEX_ALPHA_BASE + wide;
    endfunction

endpackage

FILE: rtl/nsc_input_stage.sv
// Input register: holds one byte item until the checker core takes it.
module nsc_input_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             result_free,
    output nsc_pkg::nsc_byte_t core_in
);

    logic       valid_reg;
    logic       valid_next;
    logic       last_reg;
    logic [7:0] data_reg;
    logic       advance;

    // A non-final byte always moves on; a final byte needs room for its verdict
    assign advance    = valid_reg && (!last_reg || result_free);
    assign item_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign core_in.step = advance;
    assign core_in.last = last_reg;
    assign core_in.data = data_reg;

endmodule

FILE: rtl/nsc_core.sv
// Sentence state tracking and verdict logic, one byte per cycle while the input register steps bytes in.
module nsc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nsc_pkg::nsc_byte_t    core_in,
    output nsc_pkg::nsc_verdict_t verdict
);

    logic [7:0]  pos_reg, pos_next;
    logic        start_ok_reg, start_ok_next;
    logic [7:0]  xor_reg, xor_next;
    logic [23:0] type_reg, type_next;
    logic [7:0]  tail_reg  [nsc_pkg::TAIL_DEPTH];
    logic [7:0]  tail_next [nsc_pkg::TAIL_DEPTH];
    logic [7:0]  b;
    logic        bad_term;
    logic        bad_sum;

    assign b = core_in.data;

    // State update for the incoming byte
    always_comb
    begin
        start_ok_next = start_ok_reg;
        if (pos_reg == 8'd0)
            start_ok_next = (b == nsc_pkg::CH_BANG) || (b == nsc_pkg::CH_DOLLAR);

        type_next = type_reg;
        case (pos_reg)
            nsc_pkg::TYPE_POS0: type_next[7:0]   = b;
            nsc_pkg::TYPE_POS1: type_next[15:8]  = b;
            nsc_pkg::TYPE_POS2: type_next[23:16] = b;
            default:            type_next        = type_reg;
        endcase

        // Oldest tail byte joins the checksum once it is known not to be a trailer
        xor_next = xor_reg;
        if (pos_reg >= nsc_pkg::XOR_START_POS)
            xor_next = xor_reg ^ tail_reg[0];

        for (int k = 0; k < nsc_pkg::TAIL_DEPTH - 1; k++)
            tail_next[k] = tail_reg[k + 1];
        tail_next[nsc_pkg::TAIL_DEPTH - 1] = b;

        pos_next = (pos_reg == nsc_pkg::POS_MAX) ? pos_reg : pos_reg + 8'd1;
    end

    // Verdict for a sentence ending with this byte
    always_comb
    begin
        bad_term = (pos_next < nsc_pkg::MIN_LEN)
                || (tail_next[4] != nsc_pkg::CH_LF)
                || (tail_next[3] != nsc_pkg::CH_CR)
                || (tail_next[0] != nsc_pkg::CH_STAR);
        bad_sum  = (tail_next[1] != nsc_pkg::hex_digit(xor_next[7:4]))
                || (tail_next[2] != nsc_pkg::hex_digit(xor_next[3:0]));

        if (pos_next > nsc_pkg::MAX_LEN)
            verdict.status = nsc_pkg::ST_TOO_LONG;
        else if (!start_ok_next)
            verdict.status = nsc_pkg::ST_BAD_START;
        else if (bad_term)
            verdict.status = nsc_pkg::ST_BAD_TERM;
        else if (bad_sum)
            verdict.status = nsc_pkg::ST_BAD_SUM;
        else
            verdict.status = nsc_pkg::ST_GOOD;

        verdict.checksum = xor_next;
        verdict.length   = pos_next;
        verdict.stype    = type_next;
    end

    // Sentence state; cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 8'd0;
            start_ok_reg <= 1'b0;
            xor_reg      <= 8'd0;
            type_reg     <= 24'd0;
            for (int k = 0; k < nsc_pkg::TAIL_DEPTH; k++)
                tail_reg[k] <= 8'd0;
        end
        else if (core_in.step)
        begin
            if (core_in.last)
            begin
                pos_reg      <= 8'd0;
                start_ok_reg <= 1'b0;
                xor_reg      <= 8'd0;
                type_reg     <= 24'd0;
                for (int k = 0; k < nsc_pkg::TAIL_DEPTH; k++)
                    tail_reg[k] <= 8'd0;
            end
            else
            begin
                pos_reg      <= pos_next;
                start_ok_reg <= start_ok_next;
                xor_reg      <= xor_next;
                type_reg     <= type_next;
                for (int k = 0; k < nsc_pkg::TAIL_DEPTH; k++)
                    tail_reg[k] <= tail_next[k];
            end
        end
    end

    // Sentence state starts over after every verdict
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        core_in.step && core_in.last |=> pos_reg == 8'd0 && xor_reg == 8'd0
                                         && type_reg == 24'd0)
        else $error("sentence state not cleared after final byte");

    // Nothing enters the checksum before byte position XOR_START_POS is handled
    a_xor_quiet_early: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= nsc_pkg::XOR_START_POS |-> xor_reg == 8'd0)
        else $error("checksum accumulated too early");

    // A good verdict always has a plausible length
    a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
        core_in.step && core_in.last && verdict.status == nsc_pkg::ST_GOOD
        |-> verdict.length >= nsc_pkg::MIN_LEN && verdict.length <= nsc_pkg::MAX_LEN)
        else $error("good verdict with impossible length");

endmodule

FILE: rtl/nsc_result_reg.sv
// Result register: holds one verdict item until it is taken.
module nsc_result_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  nsc_pkg::nsc_verdict_t verdict,
    output logic                  result_free,
    output logic                  verdict_valid,
    input  logic                  verdict_ready,
    output logic [2:0]            status,
    output logic [7:0]            computed_checksum,
    output logic [7:0]            sentence_length,
    output logic [23:0]           sentence_type
);

    logic                  valid_reg;
    logic                  valid_next;
    nsc_pkg::nsc_verdict_t verdict_reg;

    assign result_free = !valid_reg || verdict_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (verdict_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            verdict_reg <= verdict;
    end

    assign verdict_valid     = valid_reg;
    assign status            = verdict_reg.status;
    assign computed_checksum = verdict_reg.checksum;
    assign sentence_length   = verdict_reg.length;
    assign sentence_type     = verdict_reg.stype;

endmodule

FILE: rtl/nmea_sentence_checker_unit.sv
// NMEA sentence checker top level: input register, checker core, result register.
// A final byte passes through the input register, then its verdict is loaded into the result register.
// Throughput: one byte per cycle, except while a final byte waits for the result register.
// Input is held only while a final byte waits for the result register to free up.
// Reset (rst_n low, asynchronous) empties both registers and clears sentence state.
module nmea_sentence_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        verdict_valid,
    input  logic        verdict_ready,
    output logic [2:0]  status,
    output logic [7:0]  computed_checksum,
    output logic [7:0]  sentence_length,
    output logic [23:0] sentence_type
);

    nsc_pkg::nsc_byte_t    core_in;
    nsc_pkg::nsc_verdict_t verdict;
    logic                  result_free;

    nsc_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .result_free (result_free),
        .core_in     (core_in)
    );

    nsc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .core_in (core_in),
        .verdict (verdict)
    );

    nsc_result_reg u_result (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (core_in.step && core_in.last),
        .verdict           (verdict),
        .result_free       (result_free),
        .verdict_valid     (verdict_valid),
        .verdict_ready     (verdict_ready),
        .status            (status),
        .computed_checksum (computed_checksum),
        .sentence_length   (sentence_length),
        .sentence_type     (sentence_type)
    );

endmodule

FILE: tb/nsc_verdict_checker.sv
// Watches both channels of the sentence checker, predicts each verdict and compares it.
module nsc_verdict_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        verdict_valid,
    input  logic        verdict_ready,
    input  logic [2:0]  status,
    input  logic [7:0]  computed_checksum,
    input  logic [7:0]  sentence_length,
    input  logic [23:0] sentence_type,
    output int          fail_count,
    output int          outstanding,
    output int          checked,
    output logic [4:0]  status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Sentence state of the predictor
    logic [7:0]  pos;
    logic        start_good;
    logic [7:0]  xor_acc;
    logic [7:0]  tail [0:4];
    logic [23:0] type_acc;

    // Verdicts predicted but not yet seen on the output
    nsc_pkg::nsc_verdict_t verdicts_due[$];

    // Upper-case ASCII digit for one nibble
    function automatic logic [7:0] ascii_hex(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return 8'("A") + 8'(n) - 8'd10;
    endfunction

    task automatic clear_sentence();
        pos = '0;
        start_good = 1'b0;
        xor_acc = '0;
        type_acc = '0;
        for (int k = 0; k < nsc_pkg::TAIL_DEPTH; k++)
            tail[k] = '0;
    endtask

    // Advance the sentence state by one byte; a final byte yields a verdict
    task automatic track_sentence_byte(input logic [7:0] b, input logic fin);
        logic [7:0]            idx;
        nsc_pkg::nsc_verdict_t v;
        idx = pos;
        if (idx == 8'd0)
            start_good = (b == nsc_pkg::CH_BANG) || (b == nsc_pkg::CH_DOLLAR);
        if (idx >= nsc_pkg::TYPE_POS0 && idx <= nsc_pkg::TYPE_POS2)
            type_acc |= 24'(b) << (8 * (idx - nsc_pkg::TYPE_POS0));
        // the byte dropping out of the window is part of the checksum span
        if (idx >= nsc_pkg::XOR_START_POS)
            xor_acc ^= tail[0];
        for (int k = 0; k < nsc_pkg::TAIL_DEPTH - 1; k++)
            tail[k] = tail[k + 1];
        tail[nsc_pkg::TAIL_DEPTH - 1] = b;
        if (pos != nsc_pkg::POS_MAX)
            pos++;
        if (fin)
        begin
            if (pos > nsc_pkg::MAX_LEN)
                v.status = nsc_pkg::ST_TOO_LONG;
            else if (!start_good)
                v.status = nsc_pkg::ST_BAD_START;
            else if (pos < nsc_pkg::MIN_LEN || tail[4] != nsc_pkg::CH_LF ||
                     tail[3] != nsc_pkg::CH_CR || tail[0] != nsc_pkg::CH_STAR)
                v.status = nsc_pkg::ST_BAD_TERM;
            else if (tail[1] != ascii_hex(xor_acc[7:4]) ||
                     tail[2] != ascii_hex(xor_acc[3:0]))
                v.status = nsc_pkg::ST_BAD_SUM;
            else
                v.status = nsc_pkg::ST_GOOD;
            v.checksum = xor_acc;
            v.length = pos;
            v.stype = type_acc;
            verdicts_due.push_back(v);
            clear_sentence();
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Compare one accepted verdict with the oldest prediction
    task automatic check_verdict();
        nsc_pkg::nsc_verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            note_failure($sformatf("verdict with none due (status %0d, length %0d)",
                                   status, sentence_length));
            return;
        end
        want = verdicts_due.pop_front();
        checked++;
        status_seen[want.status] = 1'b1;
        if (status !== want.status)
            note_failure($sformatf("verdict %0d status: expected %s, got %0d",
                                   checked, want.status.name(), status));
        if (computed_checksum !== want.checksum)
            note_failure($sformatf("verdict %0d checksum: expected 0x%02h, got 0x%02h",
                                   checked, want.checksum, computed_checksum));
        if (sentence_length !== want.length)
            note_failure($sformatf("verdict %0d length: expected %0d, got %0d",
                                   checked, want.length, sentence_length));
        if (sentence_type !== want.stype)
            note_failure($sformatf("verdict %0d type: expected 0x%06h, got 0x%06h",
                                   checked, want.stype, sentence_type));
    endtask

    initial
    begin
        fail_count = 0;
        outstanding = 0;
        checked = 0;
        status_seen = '0;
        clear_sentence();
    end

    // Input side first: a verdict never leaves on the edge its final byte enters
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sentence();
            verdicts_due.delete();
        end
        else
        begin
            if (item_valid && item_ready)
                track_sentence_byte(data_byte, last_byte);
            if (verdict_valid && verdict_ready)
                check_verdict();
        end
        outstanding = verdicts_due.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the sentence checker testbench: clock, reset, sentence stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 900;

    typedef enum int {
        K_GOOD,
        K_BAD_START,
        K_BAD_SUM,
        K_LOWER_HEX,
        K_BAD_TAIL,
        K_SHORT,
        K_NOISE
    } line_kind_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        verdict_valid;
    logic        verdict_ready;
    logic [2:0]  status;
    logic [7:0]  computed_checksum;
    logic [7:0]  sentence_length;
    logic [23:0] sentence_type;

    int          fail_count;
    int          outstanding;
    int          checked;
    logic [4:0]  status_seen;

    logic [7:0]  line_q[$];
    int          burst_left;
    int          bytes_sent;
    int          lines_sent;
    int          long_lines;
    int          cycle_count;

    // Receiver stall state
    int          ready_mode;
    int          mode_left;
    logic [7:0]  ready_mask;

    nmea_sentence_checker_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .data_byte         (data_byte),
        .last_byte         (last_byte),
        .verdict_valid     (verdict_valid),
        .verdict_ready     (verdict_ready),
        .status            (status),
        .computed_checksum (computed_checksum),
        .sentence_length   (sentence_length),
        .sentence_type     (sentence_type)
    );

    nsc_verdict_checker mon (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .data_byte         (data_byte),
        .last_byte         (last_byte),
        .verdict_valid     (verdict_valid),
        .verdict_ready     (verdict_ready),
        .status            (status),
        .computed_checksum (computed_checksum),
        .sentence_length   (sentence_length),
        .sentence_type     (sentence_type),
        .fail_count        (fail_count),
        .outstanding       (outstanding),
        .checked           (checked),
        .status_seen       (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts still due", cycle_count,
                     outstanding);
            $display("[nmea_sentence_checker_unit] ERROR");
            $finish;
        end
    end

    // Receiver: switches between always ready, random, a rotating mask and heavy stall
    initial
    begin
        verdict_ready = 1'b0;
        ready_mode = 0;
        mode_left = 0;
        ready_mask = 8'hFF;
    end
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(30, 200);
            ready_mask = 8'($urandom()) | 8'h01;
        end
        mode_left--;
        ready_mask = {ready_mask[6:0], ready_mask[7]};
        case (ready_mode)
            0: verdict_ready <= 1'b1;
            1: verdict_ready <= 1'($urandom_range(0, 1));
            2: verdict_ready <= ready_mask[0];
            default: verdict_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    // Mostly field-like characters, sometimes any byte at all
    function automatic logic [7:0] body_char();
        string charset;
        charset = "GPRMCAVTXWNSE0123456789,.-";
        if ($urandom_range(0, 9) < 7)
            return charset[$urandom_range(0, charset.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Present one item and hold it until taken; entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(40, 80);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 20);
                gap = $urandom_range(0, 12);
            end
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        item_valid <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            push_byte(line_q[i], i == line_q.size() - 1);
        lines_sent++;
        if (line_q.size() > 255)
            long_lines++;
    endtask

    task automatic send_text(input string s, input bit add_crlf);
        line_q.delete();
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
        if (add_crlf)
        begin
            line_q.push_back(nsc_pkg::CH_CR);
            line_q.push_back(nsc_pkg::CH_LF);
        end
        send_line();
    endtask

    // Build a framed sentence with a body of the given size, then damage it per kind
    task automatic build_line(input int body_len, input line_kind_t kind);
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        int         spot;
        line_q.delete();
        case (kind)
            K_SHORT:
            begin
                n = $urandom_range(1, 5);
                line_q.push_back($urandom_range(0, 1) ? nsc_pkg::CH_DOLLAR : body_char());
                for (int i = 1; i < n; i++)
                    line_q.push_back(body_char());
            end
            K_NOISE:
            begin
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++)
                    line_q.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                sum = '0;
                line_q.push_back($urandom_range(0, 1) ? nsc_pkg::CH_DOLLAR
                                                      : nsc_pkg::CH_BANG);
                for (int i = 0; i < body_len; i++)
                begin
                    b = body_char();
                    sum ^= b;
                    line_q.push_back(b);
                end
                if (kind == K_BAD_SUM)
                    sum ^= 8'($urandom_range(1, 255));
                line_q.push_back(nsc_pkg::CH_STAR);
                line_q.push_back(hex_char(sum[7:4], kind == K_LOWER_HEX));
                line_q.push_back(hex_char(sum[3:0], kind == K_LOWER_HEX));
                line_q.push_back(nsc_pkg::CH_CR);
                line_q.push_back(nsc_pkg::CH_LF);
                if (kind == K_BAD_START)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == nsc_pkg::CH_BANG || b == nsc_pkg::CH_DOLLAR);
                    line_q[0] = b;
                end
                if (kind == K_BAD_TAIL)
                begin
                    case ($urandom_range(0, 2))
                        0: spot = line_q.size() - 5;
                        1: spot = line_q.size() - 2;
                        default: spot = line_q.size() - 1;
                    endcase
                    line_q[spot] = line_q[spot] ^ 8'($urandom_range(1, 255));
                end
            end
        endcase
    endtask

    function automatic line_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return K_GOOD;
        if (r < 63) return K_BAD_START;
        if (r < 71) return K_BAD_SUM;
        if (r < 79) return K_LOWER_HEX;
        if (r < 87) return K_BAD_TAIL;
        if (r < 92) return K_SHORT;
        return K_NOISE;
    endfunction

    function automatic int pick_body_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 30);
        if (r < 97)
            return $urandom_range(int'(nsc_pkg::MAX_LEN) - 12, int'(nsc_pkg::MAX_LEN) - 2);
        return $urandom_range(245, 300);
    endfunction

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        lines_sent = 0;
        long_lines = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one-byte sentences at both byte extremes
        line_q = '{8'h00};
        send_line();
        line_q = '{8'hFF};
        send_line();
        // too short to hold a terminator, type bytes missing
        send_text("$GP", 1'b0);
        // shortest good sentence, then a frame of the same shape with a wrong checksum
        send_text("$*00", 1'b1);
        send_text("!*01", 1'b1);
        // small good sentence with a nonzero checksum
        send_text("$AB*03", 1'b1);

        // Boundary sentences: byte count saturation, exactly MAX_LEN, one past it
        build_line(260, K_GOOD);
        send_line();
        build_line(int'(nsc_pkg::MAX_LEN) - 6, K_GOOD);
        send_line();
        build_line(int'(nsc_pkg::MAX_LEN) - 5, K_GOOD);
        send_line();

        // Random sentences
        while (bytes_sent < BYTE_TARGET)
        begin
            build_line(pick_body_len(), pick_kind());
            send_line();
        end
        item_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d sentences, %0d of them past 255 bytes",
                 bytes_sent, lines_sent, long_lines);
        $display("checked %0d verdicts, status codes hit %b, %0d mismatches",
                 checked, status_seen, fail_count);
        if (fail_count == 0)
            $display("[nmea_sentence_checker_unit] OK");
        else
            $display("[nmea_sentence_checker_unit] ERROR");
        $finish;
    end

endmodule
